FILE: hdl/sgi_pkg.sv
// ----------------------------------------------------------------------------
// sgi_pkg: shared types for the segment intersection core
// Holds the per-request control group that travels down the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package sgi_pkg;

  // Control bits that ride along with each request through the divider row.
  typedef struct packed {
    logic hit;
    logic neg_x;
    logic neg_y;
  } sgi_ctl_t;

endpackage

`default_nettype wire

FILE: hdl/sgi_front.sv
// ----------------------------------------------------------------------------
// sgi_front: cross products, hit test and dividend products
// Four pipeline stages: differences, products, numerators and hit, dividends.
// ----------------------------------------------------------------------------
`default_nettype none

module sgi_front #(
  parameter int C = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  output logic                    ready_o,
  input  wire logic [8*C-1:0]     coords_i,
  output logic                    valid_o,
  input  wire logic               ready_i,
  output logic [3*C+3:0]          num_x_o,
  output logic [3*C+3:0]          num_y_o,
  output logic [2*C+2:0]          den_o,
  output logic [C-1:0]            base_x_o,
  output logic [C-1:0]            base_y_o,
  output sgi_pkg::sgi_ctl_t       ctl_o
);

  localparam int PW = 2*C + 2;
  localparam int DW = 2*C + 3;
  localparam int NW = 3*C + 4;

  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  assign en4 = !v4_q || ready_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // Stage 1: coordinate differences.
  logic [C-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
  assign ax0 = coords_i[0*C +: C];
  assign ay0 = coords_i[1*C +: C];
  assign ax1 = coords_i[2*C +: C];
  assign ay1 = coords_i[3*C +: C];
  assign bx0 = coords_i[4*C +: C];
  assign by0 = coords_i[5*C +: C];
  assign bx1 = coords_i[6*C +: C];
  assign by1 = coords_i[7*C +: C];

  logic signed [C:0] dax_q, day_q, dbx_q, dby_q, dsx_q, dsy_q;
  logic [C-1:0] bx1_q, by1_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      dax_q <= {ax1[C-1], ax1} - {ax0[C-1], ax0};
      day_q <= {ay1[C-1], ay1} - {ay0[C-1], ay0};
      dbx_q <= {bx1[C-1], bx1} - {bx0[C-1], bx0};
      dby_q <= {by1[C-1], by1} - {by0[C-1], by0};
      dsx_q <= {ax0[C-1], ax0} - {bx0[C-1], bx0};
      dsy_q <= {ay0[C-1], ay0} - {by0[C-1], by0};
      bx1_q <= ax0;
      by1_q <= ay0;
    end
  end

  // Stage 2: the six partial cross products.
  logic signed [PW-1:0] pd1_q, pd2_q, ps1_q, ps2_q, pt1_q, pt2_q;
  logic signed [C:0]    dax2_q, day2_q;
  logic [C-1:0]         bx2_q, by2_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      pd1_q  <= PW'(dax_q) * PW'(dby_q);
      pd2_q  <= PW'(dbx_q) * PW'(day_q);
      ps1_q  <= PW'(dax_q) * PW'(dsy_q);
      ps2_q  <= PW'(day_q) * PW'(dsx_q);
      pt1_q  <= PW'(dbx_q) * PW'(dsy_q);
      pt2_q  <= PW'(dby_q) * PW'(dsx_q);
      dax2_q <= dax_q;
      day2_q <= day_q;
      bx2_q  <= bx1_q;
      by2_q  <= by1_q;
    end
  end

  // Stage 3: denominator, numerators, hit test and magnitudes.
  logic signed [DW-1:0] den_c, sn_c, tn_c;
  logic                 hit_c;
  assign den_c = {pd1_q[PW-1], pd1_q} - {pd2_q[PW-1], pd2_q};
  assign sn_c  = {ps1_q[PW-1], ps1_q} - {ps2_q[PW-1], ps2_q};
  assign tn_c  = {pt1_q[PW-1], pt1_q} - {pt2_q[PW-1], pt2_q};

  always_comb begin
    if (den_c > 0) begin
      hit_c = (sn_c >= 0) && (sn_c <= den_c) && (tn_c >= 0) && (tn_c <= den_c);
    end else if (den_c < 0) begin
      hit_c = (sn_c <= 0) && (sn_c >= den_c) && (tn_c <= 0) && (tn_c >= den_c);
    end else begin
      hit_c = 1'b0;
    end
  end

  logic [DW-1:0] tmag_q, dmag_q;
  logic [C:0]    daxm_q, daym_q;
  logic [C-1:0]  bx3_q, by3_q;
  sgi_pkg::sgi_ctl_t ctl3_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      tmag_q       <= tn_c[DW-1] ? DW'(-tn_c) : DW'(tn_c);
      dmag_q       <= den_c[DW-1] ? DW'(-den_c) : DW'(den_c);
      daxm_q       <= dax2_q[C] ? (C+1)'(-dax2_q) : (C+1)'(dax2_q);
      daym_q       <= day2_q[C] ? (C+1)'(-day2_q) : (C+1)'(day2_q);
      ctl3_q.hit   <= hit_c;
      ctl3_q.neg_x <= tn_c[DW-1] ^ dax2_q[C] ^ den_c[DW-1];
      ctl3_q.neg_y <= tn_c[DW-1] ^ day2_q[C] ^ den_c[DW-1];
      bx3_q        <= bx2_q;
      by3_q        <= by2_q;
    end
  end

  // Stage 4: dividends |T|*|dA| per axis.
  always_ff @(posedge clk_i) begin
    if (en4) begin
      num_x_o  <= NW'(tmag_q) * NW'(daxm_q);
      num_y_o  <= NW'(tmag_q) * NW'(daym_q);
      den_o    <= dmag_q;
      base_x_o <= bx3_q;
      base_y_o <= by3_q;
      ctl_o    <= ctl3_q;
    end
  end

  assign valid_o = v4_q;

endmodule

`default_nettype wire

FILE: hdl/sgi_div_cell.sv
// ----------------------------------------------------------------------------
// sgi_div_cell: one restoring division step for both axes
// Each cell retires one quotient bit and hands the request to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module sgi_div_cell #(
  parameter int C = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  output logic                    ready_o,
  input  wire logic [3*C+3:0]     wx_i,
  input  wire logic [3*C+3:0]     wy_i,
  input  wire logic [2*C+2:0]     den_i,
  input  wire logic [C-1:0]       base_x_i,
  input  wire logic [C-1:0]       base_y_i,
  input  wire sgi_pkg::sgi_ctl_t  ctl_i,
  output logic                    valid_o,
  input  wire logic               ready_i,
  output logic [3*C+3:0]          wx_o,
  output logic [3*C+3:0]          wy_o,
  output logic [2*C+2:0]          den_o,
  output logic [C-1:0]            base_x_o,
  output logic [C-1:0]            base_y_o,
  output sgi_pkg::sgi_ctl_t       ctl_o
);

  localparam int DW = 2*C + 3;
  localparam int NW = 3*C + 4;

  logic v_q, en;
  assign en      = !v_q || ready_i;
  assign ready_o = en;
  assign valid_o = v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= valid_i;
    end
  end

  // The word holds the partial remainder on top, then the dividend bits still
  // to come, then the quotient bits found so far.
  function automatic logic [NW-1:0] div_step(logic [NW-1:0] w, logic [DW-1:0] d);
    logic [DW:0] cand;
    logic [DW:0] diff;
    logic        take;
    cand = w[NW-1:C];
    diff = cand - {1'b0, d};
    take = (cand >= {1'b0, d});
    return {take ? diff[DW-1:0] : cand[DW-1:0], w[C-1:0], take};
  endfunction

  always_ff @(posedge clk_i) begin
    if (en) begin
      wx_o     <= div_step(wx_i, den_i);
      wy_o     <= div_step(wy_i, den_i);
      den_o    <= den_i;
      base_x_o <= base_x_i;
      base_y_o <= base_y_i;
      ctl_o    <= ctl_i;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/segment_intersection_core.sv
// Throughput: one request per cycle while m_axis_tready does not stall it; four
// front stages, a row of COORD_BITS+1 division cells (one quotient bit each) and
// an output register. Each stage holds its request while the next one is full,
// so bubbles collapse.
// Reset: rst_ni is asynchronous and active low and empties every stage.
// ----------------------------------------------------------------------------
// segment_intersection_core: streaming 2D segment intersection
// Reports whether two segments meet and, if they do, the meeting point.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_intersection_core #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
  input  wire logic [8*COORD_BITS-1:0]       s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // point_x, point_y, zero padding to whole bytes
  output logic [((2*COORD_BITS+7)/8)*8-1:0]  m_axis_tdata,
  // hit
  output logic                               m_axis_tuser
);

  localparam int C     = COORD_BITS;
  localparam int DW    = 2*C + 3;
  localparam int NW    = 3*C + 4;
  localparam int CELLS = C + 1;
  localparam int OW    = ((2*C+7)/8)*8;

  logic                 vld   [CELLS+1];
  logic                 rdy   [CELLS+1];
  logic [NW-1:0]        wx    [CELLS+1];
  logic [NW-1:0]        wy    [CELLS+1];
  logic [DW-1:0]        den   [CELLS+1];
  logic [C-1:0]         bsx   [CELLS+1];
  logic [C-1:0]         bsy   [CELLS+1];
  sgi_pkg::sgi_ctl_t    ctl   [CELLS+1];

  sgi_front #(.C(C)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s_axis_tvalid),
    .ready_o  (s_axis_tready),
    .coords_i (s_axis_tdata),
    .valid_o  (vld[0]),
    .ready_i  (rdy[0]),
    .num_x_o  (wx[0]),
    .num_y_o  (wy[0]),
    .den_o    (den[0]),
    .base_x_o (bsx[0]),
    .base_y_o (bsy[0]),
    .ctl_o    (ctl[0])
  );

  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    sgi_div_cell #(.C(C)) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .valid_i  (vld[k]),
      .ready_o  (rdy[k]),
      .wx_i     (wx[k]),
      .wy_i     (wy[k]),
      .den_i    (den[k]),
      .base_x_i (bsx[k]),
      .base_y_i (bsy[k]),
      .ctl_i    (ctl[k]),
      .valid_o  (vld[k+1]),
      .ready_i  (rdy[k+1]),
      .wx_o     (wx[k+1]),
      .wy_o     (wy[k+1]),
      .den_o    (den[k+1]),
      .base_x_o (bsx[k+1]),
      .base_y_o (bsy[k+1]),
      .ctl_o    (ctl[k+1])
    );
  end

  // Output register: apply the sign of the quotient and add the start point.
  logic          out_v_q, out_en;
  logic [C-1:0]  px_q, py_q;
  logic          hit_q;
  logic [C:0]    qx, qy;
  logic [C+1:0]  sum_x, sum_y;

  assign out_en       = !out_v_q || m_axis_tready;
  assign rdy[CELLS]   = out_en;
  assign qx           = wx[CELLS][C:0];
  assign qy           = wy[CELLS][C:0];

  always_comb begin
    if (ctl[CELLS].neg_x) begin
      sum_x = {{2{bsx[CELLS][C-1]}}, bsx[CELLS]} - {1'b0, qx};
    end else begin
      sum_x = {{2{bsx[CELLS][C-1]}}, bsx[CELLS]} + {1'b0, qx};
    end
    if (ctl[CELLS].neg_y) begin
      sum_y = {{2{bsy[CELLS][C-1]}}, bsy[CELLS]} - {1'b0, qy};
    end else begin
      sum_y = {{2{bsy[CELLS][C-1]}}, bsy[CELLS]} + {1'b0, qy};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_en) begin
      out_v_q <= vld[CELLS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      hit_q <= ctl[CELLS].hit;
      px_q  <= ctl[CELLS].hit ? sum_x[C-1:0] : '0;
      py_q  <= ctl[CELLS].hit ? sum_y[C-1:0] : '0;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tuser  = hit_q;
  assign m_axis_tdata  = OW'({py_q, px_q});

endmodule

`default_nettype wire

FILE: hdl/sgi_chk.sv
// ----------------------------------------------------------------------------
// sgi_chk: port-level checks for the segment intersection core
// Watches the result stream and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sgi_chk #(
  parameter int COORD_BITS = 16
) (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [((2*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
  input wire logic                          m_axis_tuser
);

  // A result that is not taken stays offered.
  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result request dropped before it was taken");

  // A stalled result keeps its contents.
  a_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // A miss reports a zero point.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("miss with nonzero point");

  // No result is offered in the cycle in which reset is released.
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result right after reset");

endmodule

bind segment_intersection_core sgi_chk #(.COORD_BITS(COORD_BITS)) u_sgi_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

FILE: tb/segment_intersection_checker.sv
// ----------------------------------------------------------------------------
// segment_intersection_checker: result predictor and scoreboard
// Watches both stream channels of the segment intersection core, computes
// the expected hit flag and meeting point for every accepted request, and
// compares each accepted result with the oldest pending prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_intersection_checker #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid,
  input  wire logic                         s_axis_tready,
  input  wire logic [8*COORD_BITS-1:0]      s_axis_tdata,
  input  wire logic                         m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  input  wire logic [((2*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
  input  wire logic                         m_axis_tuser,
  output int                                fail_count_o,
  output int                                pending_o
);

  typedef struct packed {
    logic                  hit;
    logic [COORD_BITS-1:0] px;
    logic [COORD_BITS-1:0] py;
  } meet_t;

  meet_t pending_meets[$];

  function automatic longint coord(input logic [8*COORD_BITS-1:0] d, input int idx);
    logic signed [COORD_BITS-1:0] v;
    begin
      v = d[idx*COORD_BITS +: COORD_BITS];
      return longint'(v);
    end
  endfunction

  // Exact 128-bit arithmetic; SystemVerilog division truncates toward zero.
  function automatic longint lerp(input longint base, input longint tn, input longint delta,
                                  input longint den);
    logic signed [127:0] prod;
    begin
      prod = 128'(signed'(tn)) * 128'(signed'(delta));
      return base + longint'(prod / 128'(signed'(den)));
    end
  endfunction

  function automatic meet_t predict_meet(input logic [8*COORD_BITS-1:0] d);
    longint ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
    longint dax, day, dbx, dby, dsx, dsy, den, sn, tn;
    meet_t r;
    begin
      ax0 = coord(d, 0); ay0 = coord(d, 1); ax1 = coord(d, 2); ay1 = coord(d, 3);
      bx0 = coord(d, 4); by0 = coord(d, 5); bx1 = coord(d, 6); by1 = coord(d, 7);
      dax = ax1 - ax0; day = ay1 - ay0; dbx = bx1 - bx0; dby = by1 - by0;
      dsx = ax0 - bx0; dsy = ay0 - by0;
      den = dax * dby - dbx * day;
      sn  = dax * dsy - day * dsx;
      tn  = dbx * dsy - dby * dsx;
      r = '0;
      if (den > 0) r.hit = sn >= 0 && sn <= den && tn >= 0 && tn <= den;
      else if (den < 0) r.hit = sn <= 0 && sn >= den && tn <= 0 && tn >= den;
      if (r.hit) begin
        r.px = COORD_BITS'(lerp(ax0, tn, dax, den));
        r.py = COORD_BITS'(lerp(ay0, tn, day, den));
      end
      return r;
    end
  endfunction

  initial begin
    fail_count_o = 0;
    pending_o = 0;
  end

  always @(posedge clk_i) begin
    meet_t want, got;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) pending_meets.push_back(predict_meet(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got.hit = m_axis_tuser;
        got.px  = m_axis_tdata[0 +: COORD_BITS];
        got.py  = m_axis_tdata[COORD_BITS +: COORD_BITS];
        if (pending_meets.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected result hit=%0b x=%h y=%h",
                                          got.hit, got.px, got.py);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = pending_meets.pop_front();
          if (want != got) begin
            if (fail_count_o < 10)
              $display("mismatch: expected hit=%0b x=%h y=%h, got hit=%0b x=%h y=%h",
                       want.hit, want.px, want.py, got.hit, got.px, got.py);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
    pending_o = pending_meets.size();
  end

endmodule

`default_nettype wire

FILE: tb/tb_segment_intersection_core.sv
// ----------------------------------------------------------------------------
// tb_segment_intersection_core: top-level testbench
// Drives directed and random segment pairs under changing idle patterns,
// including a long output stall and a full drain, and reports the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_segment_intersection_core;

  localparam int CB = 16;
  localparam int LATENCY = CB + 6;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk_i, rst_ni;
  logic s_axis_tvalid, s_axis_tready;
  logic [8*CB-1:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready;
  logic [((2*CB+7)/8)*8-1:0] m_axis_tdata;
  logic m_axis_tuser;
  int fail_count, pending;
  int send_idle_pct, recv_idle_pct;
  int hold_off_cycles;
  int idle_cycles;

  segment_intersection_core #(.COORD_BITS(CB)) DUT (.*);

  segment_intersection_checker #(.COORD_BITS(CB)) u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Receiver: random idling, plus a long hold-off when requested.
  initial begin
    m_axis_tready = 1'b0;
    recv_idle_pct = 0;
    hold_off_cycles = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off_cycles > 0) begin
        hold_off_cycles <= hold_off_cycles - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog on cycles without any accepted request or result.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic send_segments(input logic [8*CB-1:0] d);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  function automatic logic [8*CB-1:0] pack_pts(input int v[8]);
    logic [8*CB-1:0] d;
    begin
      for (int i = 0; i < 8; i++) d[i*CB +: CB] = CB'(v[i]);
      return d;
    end
  endfunction

  // Mostly pairs around a random center with a random reach, some near zero, rest noise.
  function automatic logic [8*CB-1:0] random_segments();
    int v[8];
    int cx, cy, r;
    begin
      case ($urandom_range(9))
        0, 1: for (int i = 0; i < 8; i++) v[i] = $urandom;
        2: begin
          r = $urandom_range(40);
          for (int i = 0; i < 8; i++) v[i] = int'($urandom_range(2*r)) - r;
        end
        default: begin
          r  = 1 << $urandom_range(14);
          cx = int'($urandom_range(65535)) - 32768;
          cy = int'($urandom_range(65535)) - 32768;
          if (cx > 32767 - r) cx = 32767 - r;
          if (cx < -32768 + r) cx = -32768 + r;
          if (cy > 32767 - r) cy = 32767 - r;
          if (cy < -32768 + r) cy = -32768 + r;
          for (int i = 0; i < 8; i++)
            v[i] = ((i % 2) ? cy : cx) + int'($urandom_range(2*r)) - r;
        end
      endcase
      return pack_pts(v);
    end
  endfunction

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    logic [8*CB-1:0] directed[$];
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    send_idle_pct = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Crossing, parallel, collinear, endpoint touching for both signs, extremes.
    directed.push_back(pack_pts('{0, 0, 10, 10, 0, 10, 10, 0}));
    directed.push_back(pack_pts('{0, 10, 10, 0, 0, 0, 10, 10}));
    directed.push_back(pack_pts('{0, 0, 10, 0, 0, 5, 10, 5}));
    directed.push_back(pack_pts('{0, 0, 10, 0, 5, 0, 20, 0}));
    directed.push_back(pack_pts('{0, 0, 10, 0, 10, 0, 10, 10}));
    directed.push_back(pack_pts('{0, 0, 10, 0, 10, 10, 10, 0}));
    directed.push_back(pack_pts('{0, 0, 10, 0, 0, 0, 0, 10}));
    directed.push_back(pack_pts('{0, 0, 10, 0, 0, -10, 0, 0}));
    directed.push_back(pack_pts('{0, 0, 10, 0, 11, -5, 11, 5}));
    directed.push_back(pack_pts('{0, 0, 0, 0, 0, 0, 0, 0}));
    directed.push_back(pack_pts('{-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768}));
    directed.push_back(pack_pts('{32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767}));
    directed.push_back(pack_pts('{-32768, 0, 32767, 0, 0, -32768, 0, 32767}));
    directed.push_back(pack_pts('{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767}));
    directed.push_back(pack_pts('{-32768, -32768, -32768, -32768, -32768, -32768, -32768,
                                  -32768}));
    directed.push_back(pack_pts('{0, 0, 3, 7, 0, 7, 3, 0}));
    directed.push_back(pack_pts('{0, 0, -3, -7, 0, -7, -3, 0}));
    directed.push_back(pack_pts('{-32768, -32768, 32767, -32767, 32767, -32768, -32768, -32767}));
    recv_idle_pct = 0;
    foreach (directed[i]) send_segments(directed[i]);
    drain();

    send_idle_pct = 34; recv_idle_pct = 79;
    repeat (280) send_segments(random_segments());

    // Long output stall while the sender keeps offering, then a full drain.
    hold_off_cycles = 200;
    send_idle_pct = 0;
    repeat (60) send_segments(random_segments());
    drain();

    send_idle_pct = 79; recv_idle_pct = 34;
    repeat (250) send_segments(random_segments());
    send_idle_pct = 0; recv_idle_pct = 0;
    repeat (260) send_segments(random_segments());
    drain();
    repeat (2*LATENCY) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: segment_intersection_core.f
hdl/sgi_pkg.sv
hdl/sgi_front.sv
hdl/sgi_div_cell.sv
hdl/segment_intersection_core.sv
hdl/sgi_chk.sv
tb/segment_intersection_checker.sv
tb/tb_segment_intersection_core.sv
